>>> sv/wfm_pkg.sv
package wfm_pkg;

  // linear congruential generator
  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;

  // configuration register indexes
  localparam logic [3:0] REG_WOW_INC     = 4'd0;
  localparam logic [3:0] REG_WOW_OFFSET  = 4'd1;
  localparam logic [3:0] REG_WOW_AMP     = 4'd2;
  localparam logic [3:0] REG_FLUTTER_INC = 4'd3;
  localparam logic [3:0] REG_JITTER_INC  = 4'd4;
  localparam logic [3:0] REG_FLUTTER_AMP = 4'd5;
  localparam logic [3:0] REG_NOISE_SEED  = 4'd6;
  localparam logic [3:0] REG_SMOOTHING   = 4'd7;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_TICK,
    OP_RESTART,
    OP_INDEX,
    OP_DIV,
    OP_STEP,
    OP_WHITE,
    OP_WALK,
    OP_MIX1,
    OP_MIX2,
    OP_FILT1,
    OP_FILT2,
    OP_FILT3,
    OP_OUT1,
    OP_OUT2,
    OP_ZERO
  } op_t;

  typedef struct packed {
    logic white_cond;
  } status_t;

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -64'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

>>> sv/wow_flutter_modulator_unit.sv
// channel   direction  payload                  handshake
// in        input      cmd, start_phase         in_valid / in_ready
// out       output     modulation               out_valid / out_ready
// cfg       input      cfg_index, cfg_data      cfg_valid / cfg_ready
//
// a sample tick runs through the two serial restoring divisions of the
// jitter and white-mix curves; without white mix the second division is
// skipped; a restart writes a zero result
// one item is in flight at a time
// reset is synchronous: registers take their listed reset values, noise state 1
// the result register parts the two sides: a new item is taken while a
// result still waits, and the block stalls before writing the next result
module wow_flutter_modulator_unit #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int FRACTION_BITS    = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cmd,
  input  logic [31:0]        start_phase,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] modulation,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  wfm_pkg::op_t     op;
  wfm_pkg::status_t status;

  // configuration writes are always taken; they must arrive only while idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  // sequencer: walks one item through the datapath, one operation a cycle while the result register is free
  wfm_ctrl #(
    .DIV_STEPS (FRACTION_BITS + 2)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .op        (op)
  );

  // phase, noise generator, random walk, lowpass, scaling and result register
  wfm_datapath #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .FRACTION_BITS    (FRACTION_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .start_phase (start_phase),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .status      (status),
    .modulation  (modulation)
  );

endmodule

>>> sv/wfm_ctrl.sv
module wfm_ctrl #(
  parameter int DIV_STEPS = 18
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             cmd,
  output logic             out_valid,
  input  logic             out_ready,
  input  wfm_pkg::status_t status,
  output wfm_pkg::op_t     op
);

  localparam int CW = $clog2(DIV_STEPS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_INDEX, S_DIV1, S_STEP, S_DIV2, S_WHITE, S_WALK, S_MIX1,
    S_MIX2, S_FILT1, S_FILT2, S_FILT3, S_OUT1, S_OUT2, S_ZERO
  } state_t;

  state_t state;
  logic [CW-1:0] cnt;
  logic out_free;
  logic last_step;

  assign out_free  = !out_valid || out_ready;
  assign last_step = (cnt == CW'(DIV_STEPS - 1));
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    op = wfm_pkg::OP_NONE;
    unique case (state)
      S_IDLE:  if (in_valid) op = cmd ? wfm_pkg::OP_RESTART : wfm_pkg::OP_TICK;
      S_INDEX: op = wfm_pkg::OP_INDEX;
      S_DIV1:  op = wfm_pkg::OP_DIV;
      S_STEP:  op = wfm_pkg::OP_STEP;
      S_DIV2:  op = wfm_pkg::OP_DIV;
      S_WHITE: op = wfm_pkg::OP_WHITE;
      S_WALK:  op = wfm_pkg::OP_WALK;
      S_MIX1:  op = wfm_pkg::OP_MIX1;
      S_MIX2:  op = wfm_pkg::OP_MIX2;
      S_FILT1: op = wfm_pkg::OP_FILT1;
      S_FILT2: op = wfm_pkg::OP_FILT2;
      S_FILT3: op = wfm_pkg::OP_FILT3;
      S_OUT1:  op = wfm_pkg::OP_OUT1;
      S_OUT2:  if (out_free) op = wfm_pkg::OP_OUT2;
      S_ZERO:  if (out_free) op = wfm_pkg::OP_ZERO;
      default: op = wfm_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state) inside
        S_IDLE: begin
          if (in_valid) state <= cmd ? S_ZERO : S_INDEX;
        end
        S_INDEX: begin
          cnt   <= '0;
          state <= S_DIV1;
        end
        S_DIV1: begin
          cnt <= cnt + 1'b1;
          if (last_step) state <= S_STEP;
        end
        S_STEP: begin
          cnt   <= '0;
          state <= status.white_cond ? S_DIV2 : S_WALK;
        end
        S_DIV2: begin
          cnt <= cnt + 1'b1;
          if (last_step) state <= S_WHITE;
        end
        S_WHITE: state <= S_WALK;
        S_WALK:  state <= S_MIX1;
        S_MIX1:  state <= S_MIX2;
        S_MIX2:  state <= S_FILT1;
        S_FILT1: state <= S_FILT2;
        S_FILT2: state <= S_FILT3;
        S_FILT3: state <= S_OUT1;
        S_OUT1:  state <= S_OUT2;
        S_OUT2, S_ZERO: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/wfm_datapath.sv
module wfm_datapath #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int FRACTION_BITS    = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  wfm_pkg::op_t       op,
  input  logic [31:0]        start_phase,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output wfm_pkg::status_t   status,
  output logic signed [15:0] modulation
);

  localparam int F       = FRACTION_BITS;
  localparam int W       = F + 2;
  localparam int QW      = F + 2;
  localparam int NW      = 2 * F + 9;
  localparam int DW      = F + 9;
  localparam int PW      = (2 * F + 5 > 33) ? 2 * F + 5 : 33;
  localparam int QUARTER = SINE_TABLE_DEPTH / 4;
  localparam int IW      = $clog2(SINE_TABLE_DEPTH);
  localparam int AW      = $clog2(QUARTER + 1);
  localparam int UP_SH   = (F >= 16) ? F - 16 : 0;
  localparam int DN_SH   = (F < 16) ? 16 - F : 0;

  localparam logic [F:0]            ONE  = {1'b1, {F{1'b0}}};
  localparam logic signed [F+2:0]   WONE = {3'b001, {F{1'b0}}};
  localparam logic signed [63:0]    HALF = 64'sd1 <<< (F - 1);
  localparam logic [63:0]           Q30  = 64'd1 << 30;

  // quarter-wave sine table, built at elaboration
  logic [15:0] rom [QUARTER+1];

  for (genvar gi = 0; gi <= QUARTER; gi++) begin : g_rom
    localparam logic [63:0] X  = (64'(gi) * 64'd6746518852) / 64'(SINE_TABLE_DEPTH);
    localparam logic [63:0] X2 = (X * X) >> 30;
    localparam logic [63:0] C1 = Q30 - ((X2 * Q30) >> 30) / 64'd110;
    localparam logic [63:0] C2 = Q30 - ((X2 * C1) >> 30) / 64'd72;
    localparam logic [63:0] C3 = Q30 - ((X2 * C2) >> 30) / 64'd42;
    localparam logic [63:0] C4 = Q30 - ((X2 * C3) >> 30) / 64'd20;
    localparam logic [63:0] C5 = Q30 - ((X2 * C4) >> 30) / 64'd6;
    localparam logic [63:0] S  = (X * C5) >> 30;
    localparam logic [63:0] E  = (S * 64'd32767 + (Q30 >> 1)) >> 30;
    assign rom[gi] = (E > 64'd32767) ? 16'd32767 : E[15:0];
  end

  // configuration
  logic signed [31:0] wow_increment;
  logic [31:0]        wow_offset;
  logic signed [15:0] wow_amp;
  logic [16:0]        flutter_increment;
  logic [16:0]        jitter_increment;
  logic signed [15:0] flutter_amp;
  logic [15:0]        smoothing_coeff;

  // state
  logic [31:0]         sine_phase;
  logic [31:0]         noise_state;
  logic signed [W-1:0] walk_value;
  logic signed [W-1:0] smoothed_value;

  // working registers
  logic [IW-1:0]        idx;
  logic [AW-1:0]        rom_addr;
  logic                 wow_neg;
  logic signed [15:0]   wow;
  logic [DW-1:0]        rem;
  logic [DW-1:0]        den;
  logic [QW-1:0]        nq;
  logic [F:0]           step;
  logic [F:0]           white;
  logic signed [PW-1:0] prod;
  logic signed [15:0]   wpart;

  function automatic logic [F:0] from_q16(input logic [16:0] v);
    logic [F+17:0] t;
    t = ((F + 18)'(v) << UP_SH) >> DN_SH;
    return (t > (F + 18)'(ONE)) ? ONE : t[F:0];
  endfunction

  logic [F:0]          inc;
  logic [F:0]          jit;
  logic [F:0]          a1;
  logic [F+4:0]        s5;
  logic [F+4:0]        nine;
  logic [F+4:0]        t_diff;
  logic [F:0]          t_dn;
  logic [NW-1:0]       num_up;
  logic [NW-1:0]       num_dn;
  logic [DW-1:0]       den_up;
  logic [DW-1:0]       den_dn;
  logic [DW:0]         trial;
  logic                ge;
  logic [F+1:0]        step_sum;
  logic signed [F+2:0] walk_sum;
  logic signed [F+2:0] step_s;
  logic signed [W-1:0] noise;
  logic signed [W-1:0] mixed;
  logic [63:0]         idx_prod;
  logic [1:0]          quad;
  logic [IW-1:0]       quad_base;
  logic [AW-1:0]       r;
  logic signed [15:0]  rom_val;
  logic signed [15:0]  fpart;

  assign inc  = from_q16(flutter_increment);
  assign jit  = from_q16(jitter_increment);
  assign a1   = from_q16({1'b0, smoothing_coeff});

  // white noise blend only near full rate
  assign s5     = ((F + 5)'(inc) + (F + 5)'(jit)) * (F + 5)'(5);
  assign nine   = (F + 5)'(9) << F;
  assign status.white_cond = (s5 >= nine);
  assign t_diff = s5 - nine;
  assign t_dn   = (t_diff > (F + 5)'(ONE)) ? ONE : t_diff[F:0];

  // rational curves as numerator and denominator for the serial divider
  assign num_up = (NW'(jit) * NW'(199)) << F;
  assign den_up = DW'(ONE) + DW'(jit) * DW'(198);
  assign num_dn = (NW'(t_dn) * NW'(3)) << F;
  assign den_dn = DW'(ONE) * DW'(17) - DW'(t_dn) * DW'(14);

  // one restoring step per cycle
  assign trial = {rem, nq[QW-1]};
  assign ge    = (trial >= {1'b0, den});

  assign step_sum = (F + 2)'(inc) + (F + 2)'(nq[F:0]);
  assign step_s   = $signed({2'b00, step});
  assign walk_sum = noise_state[31] ? (F + 3)'(walk_value) + step_s
                                    : (F + 3)'(walk_value) - step_s;
  assign noise    = $signed({1'b0, noise_state[31:31-F]}) - $signed({1'b0, ONE});
  assign mixed    = W'(prod >>> F);

  // sine index and quadrant fold
  assign idx_prod  = (64'(sine_phase + wow_offset) * 64'(SINE_TABLE_DEPTH)) >> 32;
  always_comb begin
    if (idx >= IW'(3 * QUARTER)) begin
      quad = 2'd3;
    end else if (idx >= IW'(2 * QUARTER)) begin
      quad = 2'd2;
    end else if (idx >= IW'(QUARTER)) begin
      quad = 2'd1;
    end else begin
      quad = 2'd0;
    end
  end
  assign quad_base = IW'(QUARTER) * IW'(quad);
  assign r         = AW'(idx - quad_base);
  assign rom_val   = $signed(rom[rom_addr]);
  assign fpart     = wfm_pkg::sat16((64'(prod) + HALF) >>> F);

  always_ff @(posedge clk) begin
    if (rst) begin
      wow_increment     <= '0;
      wow_offset        <= '0;
      wow_amp           <= '0;
      flutter_increment <= '0;
      jitter_increment  <= '0;
      flutter_amp       <= '0;
      smoothing_coeff   <= '0;
      sine_phase        <= '0;
      noise_state       <= 32'd1;
      walk_value        <= '0;
      smoothed_value    <= '0;
    end else begin
      case (op)
        wfm_pkg::OP_TICK: begin
          sine_phase  <= sine_phase + wow_increment;
          noise_state <= noise_state * wfm_pkg::LCG_MUL + wfm_pkg::LCG_ADD;
        end
        wfm_pkg::OP_RESTART: begin
          sine_phase     <= start_phase;
          walk_value     <= '0;
          smoothed_value <= '0;
        end
        wfm_pkg::OP_WALK: begin
          if (walk_sum > WONE) begin
            walk_value <= W'(WONE);
          end else if (walk_sum < -WONE) begin
            walk_value <= W'(-WONE);
          end else begin
            walk_value <= W'(walk_sum);
          end
        end
        wfm_pkg::OP_FILT3: smoothed_value <= mixed;
        default: ;
      endcase
      if (cfg_we) begin
        unique case (cfg_index)
          wfm_pkg::REG_WOW_INC:     wow_increment     <= cfg_data;
          wfm_pkg::REG_WOW_OFFSET:  wow_offset        <= cfg_data;
          wfm_pkg::REG_WOW_AMP:     wow_amp           <= cfg_data[15:0];
          wfm_pkg::REG_FLUTTER_INC: flutter_increment <= cfg_data[16:0];
          wfm_pkg::REG_JITTER_INC:  jitter_increment  <= cfg_data[16:0];
          wfm_pkg::REG_FLUTTER_AMP: flutter_amp       <= cfg_data[15:0];
          wfm_pkg::REG_NOISE_SEED: begin
            noise_state    <= (cfg_data == '0) ? 32'd1 : cfg_data;
            walk_value     <= '0;
            smoothed_value <= '0;
          end
          wfm_pkg::REG_SMOOTHING:   smoothing_coeff   <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    case (op)
      wfm_pkg::OP_TICK: begin
        rem <= DW'(num_up >> QW);
        nq  <= num_up[QW-1:0];
        den <= den_up;
      end
      wfm_pkg::OP_INDEX: idx <= idx_prod[IW-1:0];
      wfm_pkg::OP_DIV: begin
        rem <= ge ? DW'(trial - {1'b0, den}) : DW'(trial);
        nq  <= {nq[QW-2:0], ge};
      end
      wfm_pkg::OP_STEP: begin
        step     <= (step_sum > (F + 2)'(ONE)) ? ONE : step_sum[F:0];
        white    <= '0;
        rom_addr <= quad[0] ? AW'(QUARTER) - r : r;
        wow_neg  <= quad[1];
        rem      <= DW'(num_dn >> QW);
        nq       <= num_dn[QW-1:0];
        den      <= den_dn;
      end
      wfm_pkg::OP_WHITE: white <= nq[F:0];
      wfm_pkg::OP_WALK:  wow   <= wow_neg ? -rom_val : rom_val;
      wfm_pkg::OP_MIX1:
        prod <= PW'(walk_value) * PW'($signed({1'b0, ONE - white}));
      wfm_pkg::OP_MIX2:
        prod <= prod + PW'(noise) * PW'($signed({1'b0, white}));
      wfm_pkg::OP_FILT1:
        prod <= PW'(mixed) * PW'($signed({1'b0, ONE - a1}));
      wfm_pkg::OP_FILT2:
        prod <= prod + PW'(smoothed_value) * PW'($signed({1'b0, a1}));
      wfm_pkg::OP_FILT3:
        prod <= PW'(wow) * PW'(wow_amp);
      wfm_pkg::OP_OUT1: begin
        wpart <= wfm_pkg::sat16((64'(prod) + 64'sd16384) >>> 15);
        prod  <= PW'(smoothed_value) * PW'(flutter_amp);
      end
      wfm_pkg::OP_OUT2: modulation <= wfm_pkg::sat16(64'(wpart) + 64'(fpart));
      wfm_pkg::OP_ZERO: modulation <= '0;
      default: ;
    endcase
  end

endmodule

>>> verif/tb_top.sv
module tb_top;

  // block geometry, matched to the instance defaults
  localparam int DEPTH   = 1024;
  localparam int QUARTER = DEPTH / 4;
  localparam int FB      = 16;
  localparam longint ONE = longint'(1) << FB;
  localparam int SETTLE  = 2 * FB + 30;     // covers the longest tick latency
  localparam int WDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int RAND_PHASES = 7;
  localparam int PHASE_ITEMS = 125;

  logic clk, rst;
  logic in_valid, in_ready, cmd;
  logic [31:0] start_phase;
  logic out_valid, out_ready;
  logic signed [15:0] modulation;
  logic cfg_valid, cfg_ready;
  logic [3:0] cfg_index;
  logic [31:0] cfg_data;

  wow_flutter_modulator_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .start_phase(start_phase),
    .out_valid(out_valid), .out_ready(out_ready), .modulation(modulation),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow registers and state of the modulator
  logic [31:0] m_wow_inc, m_wow_off, m_seed;
  logic signed [15:0] m_wow_amp, m_flt_amp;
  logic [16:0] m_flt_inc, m_jit_inc;
  logic [15:0] m_smooth;
  logic [31:0] m_phase, m_noise;
  longint m_walk, m_filt;
  logic [15:0] sine_q [0:QUARTER];

  logic signed [15:0] expected_mod [$];
  int n_items, n_results, n_restarts, n_white, n_errors;
  int activity;
  bit hold_req, no_gaps;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // quarter-wave sine table from a truncated Q30 series
  task automatic build_sine();
    longint unsigned divs [5];
    longint unsigned x, x2, c, s, e;
    divs = '{110, 72, 42, 20, 6};
    for (int i = 0; i <= QUARTER; i++) begin
      x = (longint'(i) * 64'd6746518852) / DEPTH;
      x2 = (x * x) >> 30;
      c = 64'd1 << 30;
      for (int k = 0; k < 5; k++) c = (64'd1 << 30) - ((x2 * c) >> 30) / divs[k];
      s = (x * c) >> 30;
      e = (s * 32767 + (64'd1 << 29)) >> 30;
      sine_q[i] = (e > 32767) ? 16'd32767 : e[15:0];
    end
  endtask

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint sine_at(logic [31:0] p);
    longint unsigned idx;
    longint v;
    int q, r;
    idx = ({32'd0, p} * DEPTH) >> 32;
    q = (idx / QUARTER) & 3;
    r = idx % QUARTER;
    v = (q & 1) ? sine_q[QUARTER - r] : sine_q[r];
    return (q & 2) ? -v : v;
  endfunction

  // one sample of the modulator; updates the shadow state
  function automatic logic signed [15:0] next_modulation(logic c_in, logic [31:0] sp);
    longint wow, noise, inc, jit, stp, white, mixed, a1, wpart, fpart;
    if (c_in) begin
      m_phase = sp;
      m_walk = 0;
      m_filt = 0;
      n_restarts++;
      return 16'sd0;
    end
    m_phase = m_phase + m_wow_inc;
    wow = sine_at(m_phase + m_wow_off);
    m_noise = m_noise * wfm_pkg::LCG_MUL + wfm_pkg::LCG_ADD;
    noise = longint'(m_noise >> (31 - FB)) - ONE;
    inc = clip(m_flt_inc, 0, ONE);
    jit = clip(m_jit_inc, 0, ONE);
    stp = clip(inc + (199 * jit * ONE) / (ONE + 198 * jit), 0, ONE);
    white = 0;
    if (5 * (inc + jit) >= 9 * ONE) begin
      white = clip(5 * (inc + jit) - 9 * ONE, 0, ONE);
      white = (3 * white * ONE) / (17 * ONE - 14 * white);
      n_white++;
    end
    m_walk = clip(m_walk + (m_noise[31] ? stp : -stp), -ONE, ONE);
    mixed = (m_walk * (ONE - white) + noise * white) >>> FB;
    a1 = m_smooth;
    m_filt = ((ONE - a1) * mixed + a1 * m_filt) >>> FB;
    wpart = clip((wow * m_wow_amp + 16384) >>> 15, -32768, 32767);
    fpart = clip((m_filt * m_flt_amp + (ONE >> 1)) >>> FB, -32768, 32767);
    return 16'(clip(wpart + fpart, -32768, 32767));
  endfunction

  // register write, mirrored into the shadow copy on the handshake
  task automatic write_reg(logic [3:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    activity++;
    case (idx)
      wfm_pkg::REG_WOW_INC:     m_wow_inc = val;
      wfm_pkg::REG_WOW_OFFSET:  m_wow_off = val;
      wfm_pkg::REG_WOW_AMP:     m_wow_amp = val[15:0];
      wfm_pkg::REG_FLUTTER_INC: m_flt_inc = val[16:0];
      wfm_pkg::REG_JITTER_INC:  m_jit_inc = val[16:0];
      wfm_pkg::REG_FLUTTER_AMP: m_flt_amp = val[15:0];
      wfm_pkg::REG_NOISE_SEED: begin
        m_seed = val;
        m_noise = (val == 0) ? 32'd1 : val;
        m_walk = 0;
        m_filt = 0;
      end
      wfm_pkg::REG_SMOOTHING:   m_smooth = val[15:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // offer one item; valid stays up when the next item follows with no gap
  task automatic send_item(logic c_in, logic [31:0] sp, bit known, logic signed [15:0] val);
    int gap;
    logic signed [15:0] pred;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= c_in;
    start_phase <= sp;
    do @(posedge clk); while (!in_ready);
    activity++;
    n_items++;
    pred = next_modulation(c_in, sp);
    expected_mod.push_back(known ? val : pred);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_mod.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_all(logic [31:0] v [8]);
    for (int i = 0; i < 8; i++) write_reg(4'(i), v[i]);
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = no_gaps ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      activity++;
      n_results++;
      if (expected_mod.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result %0d", modulation);
      end else if (modulation !== expected_mod[0]) begin
        n_errors++;
        if (n_errors <= 10)
          $display("modulation mismatch: expected %0d got %0d", expected_mod[0], modulation);
        void'(expected_mod.pop_front());
      end else begin
        void'(expected_mod.pop_front());
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    int idle, last;
    idle = 0;
    last = 0;
    forever begin
      @(posedge clk);
      if (activity != last) idle = 0;
      else idle++;
      last = activity;
      if (idle >= WDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  typedef struct {
    logic c;
    logic [31:0] sp;
    bit known;
    logic signed [15:0] val;
  } row_t;

  row_t rows_reset [6];
  row_t rows_ext [10];
  logic [31:0] cv [8];

  initial begin
    rst = 1'b1;
    in_valid = 1'b0; cmd = 1'b0; start_phase = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    hold_req = 1'b0; no_gaps = 1'b0;
    n_items = 0; n_results = 0; n_restarts = 0; n_white = 0; n_errors = 0;
    activity = 0;
    build_sine();
    m_wow_inc = 0; m_wow_off = 0; m_wow_amp = 0; m_flt_inc = 0; m_jit_inc = 0;
    m_flt_amp = 0; m_seed = 1; m_smooth = 0;
    m_phase = 0; m_noise = 1; m_walk = 0; m_filt = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset both amplitudes are zero, so every sample is zero
    rows_reset = '{
      '{1'b0, 32'h0, 1'b1, 16'sd0},
      '{1'b0, 32'hffff_ffff, 1'b1, 16'sd0},
      '{1'b1, 32'hffff_ffff, 1'b1, 16'sd0},
      '{1'b0, 32'h0, 1'b1, 16'sd0},
      '{1'b1, 32'h0, 1'b1, 16'sd0},
      '{1'b0, 32'h5555_aaaa, 1'b1, 16'sd0}
    };
    foreach (rows_reset[i])
      send_item(rows_reset[i].c, rows_reset[i].sp, rows_reset[i].known, rows_reset[i].val);
    wait_drained();

    // extreme settings: full-rate flutter with white mix, quarter-turn steps
    cv = '{32'h4000_0000, 32'h0, 32'h8000, 32'd65536, 32'd65536, 32'h7fff, 32'h0, 32'hffff};
    write_all(cv);
    write_reg(4'hf, 32'hffff_ffff);
    rows_ext = '{
      '{1'b0, 32'h0, 1'b0, 16'sd0},
      '{1'b0, 32'h0, 1'b0, 16'sd0},
      '{1'b0, 32'h0, 1'b0, 16'sd0},
      '{1'b0, 32'h0, 1'b0, 16'sd0},
      '{1'b1, 32'h3fff_ffff, 1'b1, 16'sd0},
      '{1'b0, 32'h0, 1'b0, 16'sd0},
      '{1'b0, 32'h0, 1'b0, 16'sd0},
      '{1'b1, 32'hc000_0000, 1'b1, 16'sd0},
      '{1'b0, 32'h0, 1'b0, 16'sd0},
      '{1'b0, 32'h0, 1'b0, 16'sd0}
    };
    foreach (rows_ext[i])
      send_item(rows_ext[i].c, rows_ext[i].sp, rows_ext[i].known, rows_ext[i].val);
    wait_drained();

    // random phases, each with its own register setting
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        1: cv = '{32'h7fff_ffff, 32'hffff_ffff, 32'h7fff, 32'h1ffff, 32'h1ffff,
                  32'h7fff, 32'h0, 32'hffff};
        2: cv = '{32'h8000_0000, 32'h0, 32'h8000, 32'h0, 32'h0,
                  32'h8000, 32'hffff_ffff, 32'h0};
        3: cv = '{$urandom, $urandom, $urandom, $urandom_range(52000, 65536),
                  $urandom_range(52000, 65536), $urandom, $urandom, $urandom};
        default: cv = '{$urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0100_0000),
                        $urandom, $urandom, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 65536),
                        $urandom_range(0, 1) ? $urandom : $urandom_range(0, 65536),
                        $urandom, $urandom, $urandom};
      endcase
      write_all(cv);
      write_reg(4'($urandom_range(8, 15)), $urandom);
      no_gaps = (ph == 5);
      if (ph == 4) hold_req = 1'b1;   // result side stops, input backs up
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_item($urandom_range(0, 19) == 0, $urandom, 1'b0, 16'sd0);
        if (ph == 2 && n == PHASE_ITEMS / 2) wait_drained();   // sender pause
      end
      wait_drained();
      no_gaps = 1'b0;
    end

    $display("%0d items sent (%0d restarts), %0d results checked, %0d white-mix samples",
             n_items, n_restarts, n_results, n_white);
    $display("register settings covered extremes, clamped rates and out-of-range indexes");
    if (n_errors == 0 && expected_mod.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
